// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define STBG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define STBG_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/stbg_pkg.sv -----
// shared constants and types of the speaker tone beep generator
// no dependencies
package stbg_pkg;

  localparam int unsigned CLOCK_HZ_DEF    = 1193180;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned FREQ_W = 16;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned CPM_W  = 16;
  localparam int unsigned TICK_W = 32;

  localparam logic [CPM_W-1:0] CLOCKS_PER_MS_RESET = CPM_W'(1193);

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_CMD  = 1'b1;

  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;

  typedef struct packed {
    logic speaker_level;
    logic speaker_on;
    logic busy_res;
    logic command_taken;
  } out_item_t;

endpackage

// ----- hw/rtl/stbg_if.sv -----
// item channels of the speaker tone beep generator
// depends on stbg_pkg
interface stbg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [stbg_pkg::FREQ_W-1:0] freq_hz;
  logic [stbg_pkg::DUR_W-1:0]  dur_ms;

  modport source (output valid, output mode, output freq_hz, output dur_ms, input ready);
  modport sink   (input valid, input mode, input freq_hz, input dur_ms, output ready);
endinterface

interface stbg_out_if;
  logic valid;
  logic ready;
  logic speaker_level;
  logic speaker_on;
  logic busy_res;
  logic command_taken;

  modport source (output valid, output speaker_level, output speaker_on,
                  output busy_res, output command_taken, input ready);
  modport sink   (input valid, input speaker_level, input speaker_on,
                  input busy_res, input command_taken, output ready);
endinterface

// ----- hw/rtl/speaker_tone_beep_generator.sv -----
// Beep tone generator with an 8254 mode-3 style square wave and speaker gate.
// Each input item is a tick (mode 0) or a beep command (mode 1) and yields one
// result item. A tick and a rejected or frequency-zero command go straight
// to the output register; a tone command runs the clock-rate divider, one
// quotient bit per cycle, and the next item is accepted only once the
// divider is done and its result is written to the output register.
// depends on stbg_pkg, stbg_if, stbg_divider and assert_macros.svh
`include "assert_macros.svh"

module speaker_tone_beep_generator #(
  parameter int unsigned ClockHz    = stbg_pkg::CLOCK_HZ_DEF,
  parameter int unsigned CountWidth = stbg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [stbg_pkg::CPM_W-1:0] cfg_wdata_i,
  stbg_in_if.sink                    in_i,
  stbg_out_if.source                 out_o
);

  localparam int unsigned DivW = $clog2(ClockHz + 1);
  localparam int unsigned CW   = CountWidth;
  localparam int unsigned FulW = CountWidth + 2;
  localparam int unsigned TW   = stbg_pkg::TICK_W;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  function automatic logic [CW-1:0] half_hi(input logic [CW-1:0] r);
    logic [FulW-1:0] full;
    full    = (r == '0) ? (FulW'(1) << CW) : FulW'(r);
    half_hi = CW'((full + FulW'(1)) >> 1);
  endfunction

  function automatic logic [CW-1:0] half_lo(input logic [CW-1:0] r);
    logic [FulW-1:0] full;
    full    = (r == '0) ? (FulW'(1) << CW) : FulW'(r);
    half_lo = CW'(full >> 1);
  endfunction

  state_e                     state_q, state_d;
  logic [stbg_pkg::CPM_W-1:0] cpm_q;
  logic [CW-1:0]              reload_q, reload_d;
  logic [CW-1:0]              wcnt_q, wcnt_d;
  logic                       wlvl_q, wlvl_d;
  logic                       en_q, en_d;
  logic                       owned_q, owned_d;
  logic [TW-1:0]              rem_q, rem_d;
  logic                       busy_q, busy_d;
  logic                       ovalid_q, ovalid_d;
  stbg_pkg::out_item_t        out_q, out_d;

  stbg_pkg::div_stat_t div_stat;
  logic [DivW-1:0]     quot;
  logic                div_start;
  logic                in_fire;
  logic                out_wr;
  logic                taken;
  logic [CW-1:0]       new_reload;
  logic [CW-1:0]       hl, ll;
  logic [TW-1:0]       rem_dec;
  logic                own_n;

  stbg_divider #(
    .ClockHz (ClockHz),
    .QuotW   (DivW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (in_i.freq_hz),
    .stat_o    (div_stat),
    .quot_o    (quot)
  );

  assign in_i.ready = (state_q == ST_IDLE) && (!ovalid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign new_reload = CW'(quot);
  assign hl         = half_hi(reload_q);
  assign ll         = half_lo(reload_q);
  assign rem_dec    = (rem_q != '0) ? rem_q - TW'(1) : rem_q;

  always_comb begin
    state_d   = state_q;
    reload_d  = reload_q;
    wcnt_d    = wcnt_q;
    wlvl_d    = wlvl_q;
    en_d      = en_q;
    owned_d   = owned_q;
    rem_d     = rem_q;
    busy_d    = busy_q;
    div_start = 1'b0;
    out_wr    = 1'b0;
    taken     = 1'b0;
    own_n     = owned_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == stbg_pkg::MODE_TICK) begin
            out_wr = 1'b1;
            if (wcnt_q > CW'(1)) begin
              wcnt_d = wcnt_q - CW'(1);
            end else if (wlvl_q) begin
              if (ll == '0) begin
                wcnt_d = hl;
              end else begin
                wlvl_d = 1'b0;
                wcnt_d = ll;
              end
            end else begin
              wlvl_d = 1'b1;
              wcnt_d = hl;
            end
            if (busy_q) begin
              rem_d = rem_dec;
              if (rem_dec == '0) begin
                busy_d = 1'b0;
                if (owned_q) begin
                  en_d    = 1'b0;
                  owned_d = 1'b0;
                end
              end
            end
          end else if (busy_q) begin
            out_wr = 1'b1;
          end else if (in_i.freq_hz == '0) begin
            out_wr  = 1'b1;
            taken   = 1'b1;
            en_d    = 1'b0;
            owned_d = 1'b0;
          end else begin
            div_start = 1'b1;
            rem_d     = TW'({16'b0, in_i.dur_ms} * {16'b0, cpm_q});
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          out_wr   = 1'b1;
          taken    = 1'b1;
          state_d  = ST_IDLE;
          reload_d = new_reload;
          wlvl_d   = 1'b1;
          wcnt_d   = half_hi(new_reload);
          own_n    = en_q ? owned_q : 1'b1;
          en_d     = 1'b1;
          owned_d  = own_n;
          busy_d   = (rem_q != '0);
          if (rem_q == '0 && own_n) begin
            en_d    = 1'b0;
            owned_d = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_d.speaker_level = wlvl_d & en_d;
    out_d.speaker_on    = en_d;
    out_d.busy_res      = busy_d;
    out_d.command_taken = taken;

    if (out_wr) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cpm_q    <= stbg_pkg::CLOCKS_PER_MS_RESET;
      reload_q <= '0;
      wcnt_q   <= '0;
      wlvl_q   <= 1'b1;
      en_q     <= 1'b0;
      owned_q  <= 1'b0;
      rem_q    <= '0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      reload_q <= reload_d;
      wcnt_q   <= wcnt_d;
      wlvl_q   <= wlvl_d;
      en_q     <= en_d;
      owned_q  <= owned_d;
      rem_q    <= rem_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        cpm_q <= cfg_wdata_i;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.speaker_level = out_q.speaker_level;
  assign out_o.speaker_on    = out_q.speaker_on;
  assign out_o.busy_res      = out_q.busy_res;
  assign out_o.command_taken = out_q.command_taken;

  `STBG_NEVER(a_div_done_idle, div_stat.done && state_q != ST_DIV, "divider done outside divide")
  `STBG_NEVER(a_owned_not_on, owned_q && !en_q, "speaker owned while disabled")
  `STBG_NEVER(a_busy_no_ticks, busy_q && rem_q == '0, "tone busy with no ticks left")
  `STBG_ASSERT(a_start_idle, div_start |=> state_q == ST_DIV && div_stat.busy, "divide not started")

endmodule

// ----- hw/rtl/stbg_divider.sv -----
// restoring divider, one quotient bit per cycle through one subtractor
// divides the constant clock rate by a frequency; depends on stbg_pkg
module stbg_divider #(
  parameter int unsigned ClockHz = stbg_pkg::CLOCK_HZ_DEF,
  parameter int unsigned QuotW   = $clog2(stbg_pkg::CLOCK_HZ_DEF + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [stbg_pkg::FREQ_W-1:0] divisor_i,
  output stbg_pkg::div_stat_t         stat_o,
  output logic [QuotW-1:0]            quot_o
);

  localparam int unsigned FW   = stbg_pkg::FREQ_W;
  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [FW-1:0]    dvs_q;
  logic [FW-1:0]    rem_q;
  logic [QuotW-1:0] qr_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [FW:0] shifted;
  logic [FW:0] diff;
  logic        ge;

  assign shifted = {rem_q, qr_q[QuotW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      qr_q  <= QuotW'(ClockHz);
    end else if (busy_q) begin
      rem_q <= ge ? diff[FW-1:0] : shifted[FW-1:0];
      qr_q  <= {qr_q[QuotW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = qr_q;

endmodule
